// File: hdl/sac_pkg.sv
// Shared types, constants and widths for the subsampled average color block.
package sac_pkg;

    // Default structure parameters
    localparam int DEF_SAMPLE_STRIDE = 8;
    localparam int DEF_MAX_WIDTH     = 4096;
    localparam int DEF_MAX_HEIGHT    = 4096;

    // Fixed field and state widths
    localparam int FMT_W    = 3;
    localparam int WIDTH_W  = 13;
    localparam int DARK_W   = 7;
    localparam int CFG_W    = 13;
    localparam int IDX_W    = 2;
    localparam int COMP_W   = 8;
    localparam int SUM_W    = 27;
    localparam int CNT_W    = 19;
    localparam int DVD_W    = SUM_W + 1;
    localparam int STEP_W   = $clog2(DVD_W);

    // Finishing arithmetic
    localparam int AVG_W       = 9;
    localparam int PROD_W      = 16;
    localparam int RECIP_W     = 17;
    localparam int RND_W       = PROD_W + RECIP_W;
    localparam int RECIP_SHIFT = 23;
    localparam int MUTED_W     = RND_W - RECIP_SHIFT;

    localparam logic [AVG_W-1:0]   AVG_CAP   = 9'd511;
    localparam logic [DARK_W-1:0]  PERCENT   = 7'd100;
    localparam logic [PROD_W-1:0]  RND_BIAS  = 16'd50;
    localparam logic [RECIP_W-1:0] RECIP_100 = 17'd83887;
    localparam logic [MUTED_W-1:0] LIFT      = 10'd10;
    localparam logic [MUTED_W-1:0] COMP_MAX  = 10'd255;

    // Pixel format codes
    localparam logic [FMT_W-1:0] FMT_RGB565LE = 3'd0;
    localparam logic [FMT_W-1:0] FMT_RGB565BE = 3'd1;
    localparam logic [FMT_W-1:0] FMT_RGB24    = 3'd2;
    localparam logic [FMT_W-1:0] FMT_RGBA32   = 3'd3;
    localparam logic [FMT_W-1:0] FMT_BGRA32   = 3'd4;

    // Register indexes
    localparam logic [IDX_W-1:0] CFG_PIXEL_FORMAT  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_DARKEN_PERCENT = 2'd2;

    // Register reset values
    localparam logic [FMT_W-1:0]   RST_PIXEL_FORMAT  = FMT_RGB565LE;
    localparam logic [WIDTH_W-1:0] RST_IMAGE_WIDTH   = 13'd320;
    localparam logic [DARK_W-1:0]  RST_DARKEN_PERCENT = 7'd64;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic div_init;
        logic div_step;
        logic mul;
        logic rnd;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic count_zero;
        logic out_free;
    } t_dp_sts;

endpackage

// File: hdl/sac_ctrl.sv
// Sequencer for pixel intake, the shared divide loop and result hand-off.
module sac_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_last_pixel,
    output logic             o_in_stall,
    input  sac_pkg::t_dp_sts i_sts,
    output sac_pkg::t_dp_cmd o_cmd
);
    import sac_pkg::*;

    typedef enum logic [5:0] {
        ST_ACCEPT = 6'b000001,
        ST_START  = 6'b000010,
        ST_DIV    = 6'b000100,
        ST_MUL    = 6'b001000,
        ST_RND    = 6'b010000,
        ST_LOAD   = 6'b100000
    } t_state;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DVD_W - 1);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              in_acc;

    assign in_acc     = i_in_valid && (r_state == ST_ACCEPT);
    assign o_in_stall = (r_state != ST_ACCEPT);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.accept = in_acc;
        case (r_state)
            ST_ACCEPT: begin
                if (in_acc && i_last_pixel) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                n_step = '0;
                if (i_sts.count_zero) begin
                    n_state = ST_LOAD;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_state        = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_RND;
            end
            ST_RND: begin
                o_cmd.rnd = 1'b1;
                n_state   = ST_LOAD;
            end
            ST_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_ACCEPT;
                end
            end
            default: begin
                n_state = ST_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCEPT;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_last_pixel |=> r_state == ST_START)
        else $error("last pixel did not start finishing");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_step <= LAST_STEP)
        else $error("divide step counter overran");

    a_empty_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_START && i_sts.count_zero |=> r_state == ST_LOAD)
        else $error("empty image did not skip the divide");

endmodule

// File: hdl/sac_datapath.sv
// Position tracking, pixel decode, accumulators, divide lanes and output register.
module sac_datapath #(
    parameter int SAMPLE_STRIDE = sac_pkg::DEF_SAMPLE_STRIDE,
    parameter int MAX_WIDTH     = sac_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = sac_pkg::DEF_MAX_HEIGHT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [sac_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [sac_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic [31:0]                  i_pixel_bytes,
    input  logic                         i_pixel_complete,
    input  logic                         i_last_pixel,
    input  logic                         i_out_stall,
    input  sac_pkg::t_dp_cmd             i_cmd,
    output sac_pkg::t_dp_sts             o_sts,
    output logic                         o_out_valid,
    output logic [sac_pkg::COMP_W-1:0]   o_red_out,
    output logic [sac_pkg::COMP_W-1:0]   o_green_out,
    output logic [sac_pkg::COMP_W-1:0]   o_blue_out,
    output logic                         o_color_valid
);
    import sac_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int EW    = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;
    localparam int PH_W  = (SAMPLE_STRIDE > 1) ? $clog2(SAMPLE_STRIDE) : 1;
    localparam logic [PH_W-1:0] PH_LAST = PH_W'(SAMPLE_STRIDE - 1);

    // Configuration
    logic [FMT_W-1:0]   r_fmt;
    logic [WIDTH_W-1:0] r_width;
    logic [DARK_W-1:0]  r_dark;

    // Position and accumulation state
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [PH_W-1:0]  r_col_ph, r_row_ph;
    logic [SUM_W-1:0] r_sum [3];
    logic [CNT_W-1:0] r_count;

    // Finishing lanes
    logic [CNT_W-1:0] r_rem  [3];
    logic [DVD_W-1:0] r_quo  [3];
    logic [PROD_W-1:0] r_prod [3];
    logic [RND_W-1:0] r_rnd  [3];

    // Output register
    logic              r_out_valid;
    logic [COMP_W-1:0] r_out_comp [3];
    logic              r_out_cvalid;

    logic [EW-1:0]     eff_width, col_inc, w_ext;
    logic              col_wrap;
    logic [ROW_W:0]    row_inc;
    logic              row_wrap;
    logic [7:0]        b0, b1, b2;
    logic [15:0]       w16;
    logic [COMP_W-1:0] comp [3];
    logic              fmt_ok, sample;
    logic [SUM_W-1:0]  sum_add [3];
    logic [SUM_W:0]    sum_wide [3];
    logic [DARK_W-1:0] scale;
    logic [CNT_W:0]    shifted [3];
    logic              ge [3];
    logic [AVG_W-1:0]  avg [3];
    logic [MUTED_W-1:0] muted [3];
    logic [COMP_W-1:0] final_comp [3];

    // Clamp width into one..MAX_WIDTH
    always_comb begin
        w_ext = EW'(r_width);
        if (w_ext == '0) begin
            eff_width = EW'(1);
        end else if (w_ext > EW'(MAX_WIDTH)) begin
            eff_width = EW'(MAX_WIDTH);
        end else begin
            eff_width = w_ext;
        end
        col_inc  = EW'(r_col) + 1'b1;
        col_wrap = (col_inc >= eff_width);
        row_inc  = (ROW_W + 1)'(r_row) + 1'b1;
        row_wrap = (row_inc >= (ROW_W + 1)'(MAX_HEIGHT));
    end

    // Decode one pixel to 8-bit components
    always_comb begin
        b0     = i_pixel_bytes[7:0];
        b1     = i_pixel_bytes[15:8];
        b2     = i_pixel_bytes[23:16];
        w16    = (r_fmt == FMT_RGB565BE) ? {b0, b1} : {b1, b0};
        fmt_ok = 1'b1;
        comp[0] = b0;
        comp[1] = b1;
        comp[2] = b2;
        case (r_fmt)
            FMT_RGB565LE, FMT_RGB565BE: begin
                comp[0] = {w16[15:11], 3'b000};
                comp[1] = {w16[10:5], 2'b00};
                comp[2] = {w16[4:0], 3'b000};
            end
            FMT_RGB24, FMT_RGBA32: begin
                comp[0] = b0;
                comp[1] = b1;
                comp[2] = b2;
            end
            FMT_BGRA32: begin
                comp[0] = b2;
                comp[1] = b1;
                comp[2] = b0;
            end
            default: begin
                fmt_ok = 1'b0;
            end
        endcase
        sample = i_cmd.accept && i_pixel_complete && fmt_ok
                 && (r_col_ph == '0) && (r_row_ph == '0);
    end

    // Saturating sums, divide step and finishing arithmetic per lane
    always_comb begin
        scale = PERCENT - ((r_dark > PERCENT) ? PERCENT : r_dark);
        for (int k = 0; k < 3; k++) begin
            sum_wide[k] = (SUM_W + 1)'(r_sum[k]) + (SUM_W + 1)'(comp[k]);
            sum_add[k]  = sum_wide[k][SUM_W] ? '1 : sum_wide[k][SUM_W-1:0];
            shifted[k]  = {r_rem[k], r_quo[k][DVD_W-1]};
            ge[k]       = (shifted[k] >= {1'b0, r_count});
            avg[k]      = (r_quo[k] > DVD_W'(AVG_CAP)) ? AVG_CAP : r_quo[k][AVG_W-1:0];
            muted[k]    = r_rnd[k][RND_W-1:RECIP_SHIFT] + LIFT;
            final_comp[k] = (muted[k] > COMP_MAX) ? COMP_MAX[COMP_W-1:0]
                                                  : muted[k][COMP_W-1:0];
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt   <= RST_PIXEL_FORMAT;
            r_width <= RST_IMAGE_WIDTH;
            r_dark  <= RST_DARKEN_PERCENT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PIXEL_FORMAT:   r_fmt   <= i_cfg_data[FMT_W-1:0];
                CFG_IMAGE_WIDTH:    r_width <= i_cfg_data[WIDTH_W-1:0];
                CFG_DARKEN_PERCENT: r_dark  <= i_cfg_data[DARK_W-1:0];
                default: ;
            endcase
        end
    end

    // Raster position and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_col_ph <= '0;
            r_row_ph <= '0;
            r_count  <= '0;
            for (int k = 0; k < 3; k++) begin
                r_sum[k] <= '0;
            end
        end else begin
            if (i_cmd.accept) begin
                if (i_last_pixel) begin
                    r_col    <= '0;
                    r_row    <= '0;
                    r_col_ph <= '0;
                    r_row_ph <= '0;
                end else if (col_wrap) begin
                    r_col    <= '0;
                    r_col_ph <= '0;
                    r_row    <= row_wrap ? '0 : row_inc[ROW_W-1:0];
                    r_row_ph <= (row_wrap || r_row_ph == PH_LAST) ? '0 : r_row_ph + 1'b1;
                end else begin
                    r_col    <= col_inc[COL_W-1:0];
                    r_col_ph <= (r_col_ph == PH_LAST) ? '0 : r_col_ph + 1'b1;
                end
            end
            if (i_cmd.load_out) begin
                r_count <= '0;
                for (int k = 0; k < 3; k++) begin
                    r_sum[k] <= '0;
                end
            end else if (sample) begin
                r_count <= (r_count == '1) ? r_count : r_count + 1'b1;
                for (int k = 0; k < 3; k++) begin
                    r_sum[k] <= sum_add[k];
                end
            end
        end
    end

    // Restoring divide, scale multiply and reciprocal rounding
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (i_cmd.div_init) begin
                r_rem[k] <= '0;
                r_quo[k] <= DVD_W'(r_sum[k]) + DVD_W'(r_count >> 1);
            end else if (i_cmd.div_step) begin
                r_rem[k] <= ge[k] ? CNT_W'(shifted[k] - {1'b0, r_count})
                                  : shifted[k][CNT_W-1:0];
                r_quo[k] <= {r_quo[k][DVD_W-2:0], ge[k]};
            end
            if (i_cmd.mul) begin
                r_prod[k] <= PROD_W'(avg[k]) * PROD_W'(scale);
            end
            if (i_cmd.rnd) begin
                r_rnd[k] <= RND_W'(r_prod[k] + RND_BIAS) * RND_W'(RECIP_100);
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_cvalid <= !o_sts.count_zero;
            for (int k = 0; k < 3; k++) begin
                r_out_comp[k] <= o_sts.count_zero ? '0 : final_comp[k];
            end
        end
    end

    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid      = r_out_valid;
    assign o_red_out        = r_out_comp[0];
    assign o_green_out      = r_out_comp[1];
    assign o_blue_out       = r_out_comp[2];
    assign o_color_valid    = r_out_cvalid;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over an unread result");

    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> (r_count == '0) && (r_sum[0] == '0))
        else $error("accumulators not cleared after result");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_cvalid |->
            (r_out_comp[0] == '0) && (r_out_comp[1] == '0) && (r_out_comp[2] == '0))
        else $error("empty result carries nonzero color");

endmodule

// File: hdl/subsampled_average_color.sv
// Top level of the subsampled average color block.
//
// Usage: pixels of one image enter on the input channel (i_in_valid, o_in_stall)
// in raster order, one item each. Every pixel whose column and row are both
// multiples of the sample stride, and whose bytes are marked complete, is
// decoded per pixel_format and added to three component sums (unless the
// format code is unknown). The pixel marked last closes the image: one result
// item leaves on the output channel (o_out_valid, i_out_stall) with the
// darkened average color. Throughput: one pixel per cycle while inside an image.
// After the last pixel no item is taken until the image is finished: a setup
// step, the one-bit-per-cycle restoring divider (three lanes, one per
// component), a multiply step, a rounding step and a load step. An image with
// no samples skips the divider, multiply and rounding steps.
// The result sits in an output register; pixels of the next image flow in
// while it waits. If the receiver still stalls when the next result is ready,
// the block holds in its load step and stalls its input.
// Reset (synchronous, active low) restores register defaults, clears the
// position and sums, and empties the output register.
module subsampled_average_color #(
    parameter int SAMPLE_STRIDE = sac_pkg::DEF_SAMPLE_STRIDE,
    parameter int MAX_WIDTH     = sac_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = sac_pkg::DEF_MAX_HEIGHT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration write port
    input  logic                       i_cfg_we,
    input  logic [sac_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [sac_pkg::CFG_W-1:0]  i_cfg_data,
    // Pixel input channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [31:0]                i_pixel_bytes,
    input  logic                       i_pixel_complete,
    input  logic                       i_last_pixel,
    // Result output channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [sac_pkg::COMP_W-1:0] o_red_out,
    output logic [sac_pkg::COMP_W-1:0] o_green_out,
    output logic [sac_pkg::COMP_W-1:0] o_blue_out,
    output logic                       o_color_valid
);
    import sac_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequence intake, divide and result hand-off
    sac_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_last_pixel (i_last_pixel),
        .o_in_stall   (o_in_stall),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    // Track position, accumulate samples, finish and hold the result
    sac_datapath #(
        .SAMPLE_STRIDE (SAMPLE_STRIDE),
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_pixel_bytes    (i_pixel_bytes),
        .i_pixel_complete (i_pixel_complete),
        .i_last_pixel     (i_last_pixel),
        .i_out_stall      (i_out_stall),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_out_valid      (o_out_valid),
        .o_red_out        (o_red_out),
        .o_green_out      (o_green_out),
        .o_blue_out       (o_blue_out),
        .o_color_valid    (o_color_valid)
    );

endmodule
